@@ hdl/awbg_pkg.sv @@
// shared types, constants and the divider step for the white-balance gain block
package awbg_pkg;

  localparam int RatioW     = 16;
  localparam int GainW      = 16;
  localparam int GreenShift = 8;
  localparam int GreenQuotW = RatioW + GreenShift;
  localparam int GreenW     = 32;
  localparam int ProdW      = GreenW + RatioW;
  localparam int CfgIdxW    = 2;
  localparam int QueueDepth = 2;

  localparam logic [RatioW-1:0]  GoldenRgReset = 16'h02d0;
  localparam logic [RatioW-1:0]  GoldenBgReset = 16'h0287;
  localparam logic [GainW-1:0]   UnityGain     = 16'h0100;
  localparam logic [CfgIdxW-1:0] CfgGoldenRg   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgGoldenBg   = 2'd1;

  typedef struct packed {
    logic [RatioW-1:0] rg;
    logic [RatioW-1:0] bg;
    logic              err;
    logic              rg_lt;
    logic              bg_lt;
  } item_t;

  typedef struct packed {
    logic [RatioW-1:0] rg;
    logic [RatioW-1:0] bg;
  } golden_t;

  typedef struct packed {
    logic [RatioW-1:0] rem;
    logic              q;
  } div_step_t;

  // one restoring division step: shift in a bit, subtract the divisor if it fits
  function automatic div_step_t div_step(input logic [RatioW-1:0] rem,
                                         input logic nbit,
                                         input logic [RatioW-1:0] den);
    logic [RatioW:0] part;
    div_step_t       res;
    part = {rem, nbit};
    if (part >= {1'b0, den}) begin
      res.rem = RatioW'(part - {1'b0, den});
      res.q   = 1'b1;
    end else begin
      res.rem = part[RatioW-1:0];
      res.q   = 1'b0;
    end
    return res;
  endfunction

endpackage

@@ hdl/awbg_front.sv @@
// front end: golden ratio registers, item accept and case classification
module awbg_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic                                full_i,
  input  logic [awbg_pkg::RatioW-1:0]         rg_ratio_i,
  input  logic [awbg_pkg::RatioW-1:0]         bg_ratio_i,
  input  logic                                cfg_valid_i,
  input  logic [awbg_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [awbg_pkg::RatioW-1:0]         cfg_data_i,
  output logic                                cfg_ready_o,
  output logic                                busy_o,
  output logic                                push_o,
  output awbg_pkg::item_t                     item_o,
  output awbg_pkg::golden_t                   golden_o
);

  awbg_pkg::golden_t golden_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      golden_q.rg <= awbg_pkg::GoldenRgReset;
      golden_q.bg <= awbg_pkg::GoldenBgReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == awbg_pkg::CfgGoldenRg) begin
        golden_q.rg <= cfg_data_i;
      end else if (cfg_index_i == awbg_pkg::CfgGoldenBg) begin
        golden_q.bg <= cfg_data_i;
      end
    end
  end

  assign busy_o   = full_i;
  assign push_o   = start_i & ~full_i;
  assign golden_o = golden_q;

  always_comb begin
    item_o.rg    = rg_ratio_i;
    item_o.bg    = bg_ratio_i;
    item_o.err   = (rg_ratio_i == '0) | (bg_ratio_i == '0);
    item_o.rg_lt = rg_ratio_i < golden_q.rg;
    item_o.bg_lt = bg_ratio_i < golden_q.bg;
  end

endmodule

@@ hdl/awbg_queue.sv @@
// short queue of classified words between front and back
module awbg_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  awbg_pkg::item_t item_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            empty_o,
  output awbg_pkg::item_t head_o
);

  localparam int PtrW = (awbg_pkg::QueueDepth > 1) ? $clog2(awbg_pkg::QueueDepth) : 1;
  localparam int CntW = $clog2(awbg_pkg::QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(awbg_pkg::QueueDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(awbg_pkg::QueueDepth);

  awbg_pkg::item_t mem_q [awbg_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == FullCnt);
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : PtrW'(wr_ptr_q + 1'b1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : PtrW'(rd_ptr_q + 1'b1);
    end
    if (push_i && !pop_i) begin
      count_d = CntW'(count_q + 1'b1);
    end else if (pop_i && !push_i) begin
      count_d = CntW'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> !full_o)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue read while empty");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("queue count out of range");

endmodule

@@ hdl/awbg_div_green.sv @@
// pipelined restoring divider for the green candidates, one quotient bit a stage
module awbg_div_green (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic [awbg_pkg::RatioW-1:0]       dividend_i,
  input  logic [awbg_pkg::RatioW-1:0]       divisor_i,
  output logic                              out_valid_o,
  output logic [awbg_pkg::GreenQuotW-1:0]   quot_o
);

  localparam int Steps = awbg_pkg::GreenQuotW;

  logic [Steps-1:0]           vld_q;
  logic [Steps-1:0]           quot_q [Steps];
  logic [awbg_pkg::RatioW-1:0] rem_q [Steps-1];
  logic [awbg_pkg::RatioW-1:0] den_q [Steps-1];
  logic [Steps-1:0]           num_q  [Steps-1];
  logic [Steps-1:0]           num_in;
  awbg_pkg::div_step_t        step   [Steps];

  // numerator is the ratio times unity gain
  assign num_in = {dividend_i, {awbg_pkg::GreenShift{1'b0}}};

  always_comb begin
    step[0] = awbg_pkg::div_step('0, num_in[Steps-1], divisor_i);
    for (int k = 1; k < Steps; k++) begin
      step[k] = awbg_pkg::div_step(rem_q[k-1], num_q[k-1][Steps-1], den_q[k-1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Steps-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q[0] <= {{(Steps-1){1'b0}}, step[0].q};
    rem_q[0]  <= step[0].rem;
    den_q[0]  <= divisor_i;
    num_q[0]  <= {num_in[Steps-2:0], 1'b0};
    for (int k = 1; k < Steps; k++) begin
      quot_q[k] <= {quot_q[k-1][Steps-2:0], step[k].q};
    end
    for (int k = 1; k < Steps - 1; k++) begin
      rem_q[k] <= step[k].rem;
      den_q[k] <= den_q[k-1];
      num_q[k] <= {num_q[k-1][Steps-2:0], 1'b0};
    end
  end

  assign out_valid_o = vld_q[Steps-1];
  assign quot_o      = quot_q[Steps-1];

endmodule

@@ hdl/awbg_div_gain.sv @@
// pipelined saturating divider for red and blue gains, quotient clamped to 16 bits
module awbg_div_gain (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [awbg_pkg::ProdW-1:0]    dividend_i,
  input  logic [awbg_pkg::RatioW-1:0]   divisor_i,
  output logic                          out_valid_o,
  output logic [awbg_pkg::GainW-1:0]    quot_o
);

  localparam int Steps = awbg_pkg::GainW;
  localparam int HighW = awbg_pkg::ProdW - Steps;

  logic                        pre_vld_q;
  logic                        pre_sat_q;
  logic [awbg_pkg::RatioW-1:0] pre_rem_q;
  logic [awbg_pkg::RatioW-1:0] pre_den_q;
  logic [Steps-1:0]            pre_low_q;

  logic [Steps-1:0]            vld_q;
  logic [Steps-1:0]            sat_q  [Steps];
  logic [Steps-1:0]            quot_q [Steps];
  logic [awbg_pkg::RatioW-1:0] rem_q  [Steps-1];
  logic [awbg_pkg::RatioW-1:0] den_q  [Steps-1];
  logic [Steps-1:0]            low_q  [Steps-1];
  awbg_pkg::div_step_t         step   [Steps];
  logic                        sat_in;

  // quotient overflows 16 bits exactly when the upper part reaches the divisor
  assign sat_in = dividend_i[awbg_pkg::ProdW-1:Steps] >= HighW'(divisor_i);

  always_comb begin
    step[0] = awbg_pkg::div_step(pre_rem_q, pre_low_q[Steps-1], pre_den_q);
    for (int k = 1; k < Steps; k++) begin
      step[k] = awbg_pkg::div_step(rem_q[k-1], low_q[k-1][Steps-1], den_q[k-1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_vld_q <= 1'b0;
      vld_q     <= '0;
    end else begin
      pre_vld_q <= in_valid_i;
      vld_q     <= {vld_q[Steps-2:0], pre_vld_q};
    end
  end

  always_ff @(posedge clk_i) begin
    pre_sat_q <= sat_in;
    pre_rem_q <= dividend_i[Steps+awbg_pkg::RatioW-1:Steps];
    pre_den_q <= divisor_i;
    pre_low_q <= dividend_i[Steps-1:0];
    sat_q[0]  <= {Steps{pre_sat_q}};
    quot_q[0] <= {{(Steps-1){1'b0}}, step[0].q};
    rem_q[0]  <= step[0].rem;
    den_q[0]  <= pre_den_q;
    low_q[0]  <= {pre_low_q[Steps-2:0], 1'b0};
    for (int k = 1; k < Steps; k++) begin
      sat_q[k]  <= sat_q[k-1];
      quot_q[k] <= {quot_q[k-1][Steps-2:0], step[k].q};
    end
    for (int k = 1; k < Steps - 1; k++) begin
      rem_q[k] <= step[k].rem;
      den_q[k] <= den_q[k-1];
      low_q[k] <= {low_q[k-1][Steps-2:0], 1'b0};
    end
  end

  assign out_valid_o = vld_q[Steps-1];
  assign quot_o      = quot_q[Steps-1] | sat_q[Steps-1];

endmodule

@@ hdl/awbg_back.sv @@
// back end: green candidates, case selection, red and blue gains, result register
module awbg_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        item_valid_i,
  input  awbg_pkg::item_t             item_i,
  input  awbg_pkg::golden_t           golden_i,
  output logic                        done_o,
  output logic [awbg_pkg::GainW-1:0]  red_gain_o,
  output logic [awbg_pkg::GainW-1:0]  green_gain_o,
  output logic [awbg_pkg::GainW-1:0]  blue_gain_o,
  output logic                        status_o
);

  localparam int GreenLat = awbg_pkg::GreenQuotW;
  localparam int GainLat  = awbg_pkg::GainW + 1;
  localparam int GreenW   = awbg_pkg::GreenW;
  localparam int GainW    = awbg_pkg::GainW;
  localparam int RatioW   = awbg_pkg::RatioW;
  localparam int ProdW    = awbg_pkg::ProdW;

  typedef struct packed {
    logic [GainW-1:0] green;
    logic             r_unity;
    logic             b_unity;
    logic             err;
  } out_meta_t;

  awbg_pkg::item_t meta_q [GreenLat];

  logic                              gr_vld, gb_vld;
  logic [awbg_pkg::GreenQuotW-1:0]   gr_quot, gb_quot;
  logic [GreenW-1:0]                 gr_full, gb_full;
  awbg_pkg::item_t                   green_meta;

  logic              s1_vld_q;
  logic [GreenW-1:0] s1_g_q, s1_g_d;
  logic              s1_r_unity_q, s1_r_unity_d;
  logic              s1_b_unity_q, s1_b_unity_d;
  logic              s1_err_q;
  logic [RatioW-1:0] s1_rg_q, s1_bg_q;

  logic              s2_vld_q;
  logic [ProdW-1:0]  prod_r, prod_b;
  logic [ProdW-1:0]  s2_prod_r_q, s2_prod_b_q;
  logic [RatioW-1:0] s2_rg_q, s2_bg_q;
  out_meta_t         s2_meta_q;
  logic [GainW-1:0]  green_clamp;

  out_meta_t         gmeta_q [GainLat];
  logic              r_vld, b_vld;
  logic [GainW-1:0]  r_quot, b_quot;
  out_meta_t         fin_meta;
  logic              fin_vld;

  logic              done_q;
  logic [GainW-1:0]  red_q, green_q, blue_q;
  logic              status_q;

  awbg_div_green u_div_gr (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_valid_i),
    .dividend_i  (item_i.rg),
    .divisor_i   (golden_i.rg),
    .out_valid_o (gr_vld),
    .quot_o      (gr_quot)
  );

  awbg_div_green u_div_gb (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_valid_i),
    .dividend_i  (item_i.bg),
    .divisor_i   (golden_i.bg),
    .out_valid_o (gb_vld),
    .quot_o      (gb_quot)
  );

  // item word rides alongside the green dividers
  always_ff @(posedge clk_i) begin
    meta_q[0] <= item_i;
    for (int k = 1; k < GreenLat; k++) begin
      meta_q[k] <= meta_q[k-1];
    end
  end

  assign green_meta = meta_q[GreenLat-1];
  // a zero golden ratio gives an all-ones quotient
  assign gr_full = (golden_i.rg == '0) ? {GreenW{1'b1}} : GreenW'(gr_quot);
  assign gb_full = (golden_i.bg == '0) ? {GreenW{1'b1}} : GreenW'(gb_quot);

  always_comb begin
    s1_g_d       = GreenW'(awbg_pkg::UnityGain);
    s1_r_unity_d = 1'b0;
    s1_b_unity_d = 1'b0;
    if (green_meta.bg_lt && green_meta.rg_lt) begin
      s1_g_d = GreenW'(awbg_pkg::UnityGain);
    end else if (green_meta.bg_lt) begin
      s1_g_d       = gr_full;
      s1_r_unity_d = 1'b1;
    end else if (green_meta.rg_lt) begin
      s1_g_d       = gb_full;
      s1_b_unity_d = 1'b1;
    end else if (gb_full > gr_full) begin
      s1_g_d       = gb_full;
      s1_b_unity_d = 1'b1;
    end else begin
      s1_g_d       = gr_full;
      s1_r_unity_d = 1'b1;
    end
  end

  assign prod_r      = ProdW'(s1_g_q) * ProdW'(golden_i.rg);
  assign prod_b      = ProdW'(s1_g_q) * ProdW'(golden_i.bg);
  assign green_clamp = (|s1_g_q[GreenW-1:GainW]) ? {GainW{1'b1}} : s1_g_q[GainW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= gr_vld & gb_vld;
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_g_q               <= s1_g_d;
    s1_r_unity_q         <= s1_r_unity_d;
    s1_b_unity_q         <= s1_b_unity_d;
    s1_err_q             <= green_meta.err;
    s1_rg_q              <= green_meta.rg;
    s1_bg_q              <= green_meta.bg;
    s2_prod_r_q          <= prod_r;
    s2_prod_b_q          <= prod_b;
    s2_rg_q              <= s1_rg_q;
    s2_bg_q              <= s1_bg_q;
    s2_meta_q.green      <= green_clamp;
    s2_meta_q.r_unity    <= s1_r_unity_q;
    s2_meta_q.b_unity    <= s1_b_unity_q;
    s2_meta_q.err        <= s1_err_q;
  end

  awbg_div_gain u_div_r (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s2_vld_q),
    .dividend_i  (s2_prod_r_q),
    .divisor_i   (s2_rg_q),
    .out_valid_o (r_vld),
    .quot_o      (r_quot)
  );

  awbg_div_gain u_div_b (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s2_vld_q),
    .dividend_i  (s2_prod_b_q),
    .divisor_i   (s2_bg_q),
    .out_valid_o (b_vld),
    .quot_o      (b_quot)
  );

  always_ff @(posedge clk_i) begin
    gmeta_q[0] <= s2_meta_q;
    for (int k = 1; k < GainLat; k++) begin
      gmeta_q[k] <= gmeta_q[k-1];
    end
  end

  assign fin_meta = gmeta_q[GainLat-1];
  assign fin_vld  = r_vld & b_vld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= fin_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_meta.err) begin
      red_q    <= '0;
      green_q  <= '0;
      blue_q   <= '0;
      status_q <= 1'b1;
    end else begin
      red_q    <= fin_meta.r_unity ? awbg_pkg::UnityGain : r_quot;
      green_q  <= fin_meta.green;
      blue_q   <= fin_meta.b_unity ? awbg_pkg::UnityGain : b_quot;
      status_q <= 1'b0;
    end
  end

  assign done_o       = done_q;
  assign red_gain_o   = red_q;
  assign green_gain_o = green_q;
  assign blue_gain_o  = blue_q;
  assign status_o     = status_q;

  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (gr_vld == gb_vld) && (r_vld == b_vld))
    else $error("paired dividers out of step");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && status_q |-> (red_q == '0) && (green_q == '0) && (blue_q == '0))
    else $error("error word carries nonzero gains");

  a_one_unity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && !status_q |->
      (red_q == awbg_pkg::UnityGain) || (green_q == awbg_pkg::UnityGain) ||
      (blue_q == awbg_pkg::UnityGain))
    else $error("valid word has no unity channel");

endmodule

@@ hdl/awb_otp_gain_calc_core.sv @@
// top level of the white-balance gain calculation from measured color ratios
// path: queue, green dividers, select and product registers, gain dividers, result register
// throughput: one word per cycle; dividers are fully pipelined, one quotient bit per stage
// busy rises only if the two-entry queue fills, which a non-stalling back end never lets happen
// reset: asynchronous, active low; clears all valid bits and loads golden ratios 720 and 647
module awb_otp_gain_calc_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [awbg_pkg::RatioW-1:0]       rg_ratio_i,
  input  logic [awbg_pkg::RatioW-1:0]       bg_ratio_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [awbg_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [awbg_pkg::RatioW-1:0]       cfg_data_i,
  output logic                              done_o,
  output logic [awbg_pkg::GainW-1:0]        red_gain_o,
  output logic [awbg_pkg::GainW-1:0]        green_gain_o,
  output logic [awbg_pkg::GainW-1:0]        blue_gain_o,
  output logic                              status_o
);

  logic              push, full, empty;
  awbg_pkg::item_t   push_item, head_item;
  awbg_pkg::golden_t golden;

  awbg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .full_i      (full),
    .rg_ratio_i  (rg_ratio_i),
    .bg_ratio_i  (bg_ratio_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .busy_o      (busy),
    .push_o      (push),
    .item_o      (push_item),
    .golden_o    (golden)
  );

  // back end never stalls, so the head is taken whenever present
  awbg_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (~empty),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head_item)
  );

  awbg_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (~empty),
    .item_i       (head_item),
    .golden_i     (golden),
    .done_o       (done_o),
    .red_gain_o   (red_gain_o),
    .green_gain_o (green_gain_o),
    .blue_gain_o  (blue_gain_o),
    .status_o     (status_o)
  );

endmodule
